[rtl/audio_dma_interface_core_defines.svh]
// Assertion macros used by the audio DMA interface core.
`ifndef AUDIO_DMA_INTERFACE_CORE_DEFINES_SVH
`define AUDIO_DMA_INTERFACE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Checks that the consequent holds in the same cycle as the antecedent.
`define ADI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ADI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ADI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ADI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

[rtl/adi_pkg.sv]
// Types and constants of the audio DMA interface.
package adi_pkg;

	// Request kinds carried in req_type.
	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;
	localparam logic [1:0] REQ_DATA  = 2'd3;

	// Register indexes carried in reg_index.
	localparam logic [2:0] REG_ADDR     = 3'd0;
	localparam logic [2:0] REG_LENGTH   = 3'd1;
	localparam logic [2:0] REG_CONTROL  = 3'd2;
	localparam logic [2:0] REG_STATUS   = 3'd3;
	localparam logic [2:0] REG_DAC_RATE = 3'd4;
	localparam logic [2:0] REG_BIT_RATE = 3'd5;

	// Configuration registers, selected by paddr bit 2.
	localparam logic CFG_VIDEO_CLOCK = 1'b0;
	localparam logic CFG_CPU_CLOCK   = 1'b1;

	localparam logic [25:0] VIDEO_CLOCK_RESET = 26'd48681812;
	localparam logic [26:0] CPU_CLOCK_RESET   = 27'd93750000;

	// Buffer queue depth.
	localparam logic [1:0] QUEUE_SLOTS = 2'd2;

	// Width of the shared divider, set by the 27-bit CPU clock and period.
	localparam int DIV_W = 27;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [2:0]  reg_index;
		logic [31:0] write_data;
		logic [31:0] sample_word;
	} req_item_t;

	typedef struct packed {
		logic [31:0]        read_data;
		logic               irq_level;
		logic               fetch_valid;
		logic [22:0]        fetch_addr;
		logic               sample_valid;
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic [26:0]        dac_period;
		logic               bad_address;
	} rsp_item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

[rtl/adi_stream_if.sv]
// Valid/ready channel that carries one word of a given payload type.
interface adi_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/adi_divider.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
module adi_divider import adi_pkg::*; #(
	parameter int W = 27
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic [W-1:0] quotient,
	output div_status_t  status
);

	localparam int CW = $clog2(W + 1);

	logic [W:0]   rem_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic         done_q;

	logic [W:0]   rem_sh;
	logic [W+1:0] diff;

	// Shift in the next dividend bit and trial-subtract the divisor.
	assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CW'(1);
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath registers need no reset.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!diff[W+1]) begin
				rem_q <= diff[W:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient    = quo_q;
	assign status.busy = (cnt_q != '0);
	assign status.done = done_q;

endmodule

[rtl/audio_dma_interface_core.sv]
// Top level of the audio DMA interface: register file, buffer queue and DAC period sequencer.
//
// Each word on req_ch is one request: a register read, a register write, a sample tick
// or a fetched sample word. Each request gives exactly one word on rsp_ch. Reads, queue
// and control writes, ticks and sample words finish in the cycle they are accepted, so
// one can be taken every cycle while the response register is free or being drained.
// A DAC rate write does not finish on acceptance: the period is worked out by two 27-step
// divisions (video clock over rate plus one, then CPU clock over that frequency) on one
// shared radix-2 divider, and req_ch.ready stays low until the response is loaded.
// The video and CPU clock frequencies are written over the APB port at byte addresses
// 0 and 4 and should only be changed while no request is in flight.
`include "audio_dma_interface_core_defines.svh"

module audio_dma_interface_core import adi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	adi_stream_if.sink        req_ch,
	adi_stream_if.source      rsp_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_DIV_FREQ,
		S_DIV_PERIOD,
		S_REPLY
	} state_t;

	state_t state_q;

	req_item_t req_pl;
	rsp_item_t rsp_q;
	rsp_item_t rsp_n;
	rsp_item_t rsp_reply;
	logic      rsp_valid_q;
	logic      out_free;
	logic      req_accept;
	logic      is_dac_write;
	logic      rsp_load;

	// Configuration registers.
	logic [25:0] video_clock_q;
	logic [26:0] cpu_clock_q;

	// Buffer queue and control state.
	logic [23:0] buf_addr_q [2];
	logic [17:0] buf_len_q [2];
	logic [1:0]  buf_count_q;
	logic        dma_en_q;
	logic        carry_q;
	logic [13:0] dac_rate_q;
	logic [26:0] period_q;
	logic [3:0]  bit_rate_q;
	logic        irq_q;

	logic [23:0] buf_addr_n [2];
	logic [17:0] buf_len_n [2];
	logic [1:0]  buf_count_n;
	logic        dma_en_n;
	logic        carry_n;
	logic [13:0] dac_rate_n;
	logic [3:0]  bit_rate_n;
	logic        irq_n;

	// Shared divider.
	logic [DIV_W-1:0] div_dividend;
	logic [DIV_W-1:0] div_divisor;
	logic [DIV_W-1:0] div_quotient;
	logic [DIV_W-1:0] freq;
	logic [14:0]      rate_plus_one;
	logic             div_start;
	div_status_t      div_st;

	assign req_pl       = req_ch.payload;
	assign out_free     = !rsp_valid_q || rsp_ch.ready;
	assign req_ch.ready = (state_q == S_IDLE) && out_free;
	assign req_accept   = req_ch.valid && req_ch.ready;
	assign is_dac_write = (req_pl.req_type == REQ_WRITE) && (req_pl.reg_index == REG_DAC_RATE);
	assign rsp_load     = (req_accept && !is_dac_write) || ((state_q == S_REPLY) && out_free);

	assign rsp_ch.valid   = rsp_valid_q;
	assign rsp_ch.payload = rsp_q;

	// APB configuration port.
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[2])
			CFG_VIDEO_CLOCK: prdata = {6'b0, video_clock_q};
			CFG_CPU_CLOCK:   prdata = {5'b0, cpu_clock_q};
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			video_clock_q <= VIDEO_CLOCK_RESET;
			cpu_clock_q   <= CPU_CLOCK_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				CFG_VIDEO_CLOCK: video_clock_q <= pwdata[25:0];
				CFG_CPU_CLOCK:   cpu_clock_q   <= pwdata[26:0];
				default:         ;
			endcase
		end
	end

	// Divider operands: frequency first, then period from the clamped frequency.
	assign rate_plus_one = {1'b0, dac_rate_q} + 15'd1;
	assign freq          = (div_quotient == '0) ? DIV_W'(1) : div_quotient;
	assign div_start     = (state_q == S_LOAD) || ((state_q == S_DIV_FREQ) && div_st.done);
	assign div_dividend  = (state_q == S_LOAD) ? {1'b0, video_clock_q} : cpu_clock_q;
	assign div_divisor   = (state_q == S_LOAD) ? {12'b0, rate_plus_one} : freq;

	adi_divider #(
		.W(DIV_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quotient),
		.status   (div_st)
	);

	// Next queue state, and response word for a request that finishes on acceptance.
	always_comb begin
		logic        can_sample;
		logic        queue_full;
		logic        slot;
		logic [23:0] folded;
		logic [12:0] lo_sum;
		logic [17:0] len_dec;
		logic [31:0] status_word;

		buf_addr_n  = buf_addr_q;
		buf_len_n   = buf_len_q;
		buf_count_n = buf_count_q;
		dma_en_n    = dma_en_q;
		carry_n     = carry_q;
		dac_rate_n  = dac_rate_q;
		bit_rate_n  = bit_rate_q;
		irq_n       = irq_q;
		rsp_n       = '0;

		can_sample = (buf_count_q != 2'd0) && (buf_len_q[0] != '0) && dma_en_q;
		queue_full = (buf_count_q == QUEUE_SLOTS);
		slot       = buf_count_q[0];
		folded     = {buf_addr_q[0][23:13] + {10'b0, carry_q}, buf_addr_q[0][12:0]};
		lo_sum     = folded[12:0] + 13'd4;
		len_dec    = buf_len_q[0] - 18'd4;
		status_word = {queue_full, (buf_count_q != 2'd0), 4'b0, dma_en_q, 1'b1,
			3'b0, 1'b1, 19'b0, queue_full};

		unique case (req_pl.req_type)
			REQ_READ: begin
				rsp_n.read_data = (req_pl.reg_index == REG_STATUS) ? status_word
					: {14'b0, buf_len_q[0]};
			end
			REQ_WRITE: begin
				unique case (req_pl.reg_index)
					REG_ADDR: begin
						if (!queue_full) begin
							buf_addr_n[slot] = {req_pl.write_data[23:3], 3'b0};
						end
					end
					REG_LENGTH: begin
						if (!queue_full) begin
							if (buf_count_q == 2'd0) begin
								irq_n = 1'b1;
							end
							buf_len_n[slot] = {req_pl.write_data[17:3], 3'b0};
							buf_count_n     = buf_count_q + 2'd1;
						end
					end
					REG_CONTROL:  dma_en_n   = req_pl.write_data[0];
					REG_STATUS:   irq_n      = 1'b0;
					REG_DAC_RATE: dac_rate_n = req_pl.write_data[13:0];
					REG_BIT_RATE: bit_rate_n = req_pl.write_data[3:0];
					default:      rsp_n.bad_address = 1'b1;
				endcase
			end
			REQ_TICK: begin
				if (can_sample) begin
					buf_addr_n[0]     = folded;
					carry_n           = 1'b0;
					rsp_n.fetch_valid = 1'b1;
					rsp_n.fetch_addr  = folded[22:0];
				end
			end
			REQ_DATA: begin
				if (can_sample) begin
					rsp_n.sample_valid = 1'b1;
					rsp_n.left_sample  = $signed(req_pl.sample_word[31:16]);
					rsp_n.right_sample = $signed(req_pl.sample_word[15:0]);
					buf_addr_n[0]      = {folded[23:13], lo_sum};
					carry_n            = (lo_sum == '0);
					buf_len_n[0]       = len_dec;
					// End of the current buffer: pop, and promote the next one if queued.
					if (len_dec == '0) begin
						buf_count_n = buf_count_q - 2'd1;
						if (queue_full) begin
							irq_n         = 1'b1;
							buf_addr_n[0] = buf_addr_q[1];
							buf_len_n[0]  = buf_len_q[1];
						end
					end
				end
			end
			default: ;
		endcase

		rsp_n.irq_level  = irq_n;
		rsp_n.dac_period = period_q;
	end

	// Response word that closes a DAC rate write.
	always_comb begin
		rsp_reply            = '0;
		rsp_reply.irq_level  = irq_q;
		rsp_reply.dac_period = period_q;
	end

	// Queue and control registers update when a request is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_addr_q[0] <= '0;
			buf_addr_q[1] <= '0;
			buf_len_q[0]  <= '0;
			buf_len_q[1]  <= '0;
			buf_count_q   <= '0;
			dma_en_q      <= 1'b0;
			carry_q       <= 1'b0;
			dac_rate_q    <= '0;
			bit_rate_q    <= '0;
			irq_q         <= 1'b0;
		end else if (req_accept) begin
			buf_addr_q  <= buf_addr_n;
			buf_len_q   <= buf_len_n;
			buf_count_q <= buf_count_n;
			dma_en_q    <= dma_en_n;
			carry_q     <= carry_n;
			dac_rate_q  <= dac_rate_n;
			bit_rate_q  <= bit_rate_n;
			irq_q       <= irq_n;
		end
	end

	// Sequencer for DAC rate writes, with the period and the response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			period_q    <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_accept && is_dac_write) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: state_q <= S_DIV_FREQ;
				S_DIV_FREQ: begin
					if (div_st.done) begin
						state_q <= S_DIV_PERIOD;
					end
				end
				S_DIV_PERIOD: begin
					if (div_st.done) begin
						period_q <= div_quotient;
						state_q  <= S_REPLY;
					end
				end
				S_REPLY: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= (state_q == S_REPLY) ? rsp_reply : rsp_n;
			end else if (rsp_ch.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// The queue never holds more than two buffers.
	`ADI_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, buf_count_q != 2'd3, "buffer count above queue depth")

	// No request is taken while a DAC rate write is in progress.
	`ADI_ASSERT_IMP(a_busy_not_ready, clk, arst_n, state_q != S_IDLE, !req_ch.ready, "request accepted while busy")

	// The divider finishes only while the sequencer waits for it.
	`ADI_ASSERT_IMP(a_div_done_state, clk, arst_n, div_st.done, (state_q == S_DIV_FREQ) || (state_q == S_DIV_PERIOD), "divider result outside a division step")

	// A bit rate write lands in the bit rate register.
	`ADI_ASSERT_NXT(a_bit_rate_write, clk, arst_n, req_accept && (req_pl.req_type == REQ_WRITE) && (req_pl.reg_index == REG_BIT_RATE), bit_rate_q == $past(req_pl.write_data[3:0]), "bit rate not stored")

endmodule
